@@ src/pwfd_pkg.sv @@
`default_nettype none
package pwfd_pkg;

   // fixed point format and word sizes
   localparam int FRAC_BITS = 16;
   localparam int WORD_W    = 32;
   localparam int CFG_W     = 31;
   localparam int IDX_W     = 3;
   localparam int OPA_W     = WORD_W + 1;
   localparam int OPB_W     = WORD_W;
   localparam int PROD_W    = OPA_W + OPB_W;
   localparam int SH_W      = PROD_W - FRAC_BITS;
   localparam int ACC_W     = SH_W + 3;
   localparam int PC_W      = 4;

   // constants scaled to the fraction width
   localparam longint SQRT2_Q30 = 64'd1518500250;
   localparam longint SQRT2_L   = (SQRT2_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
   localparam logic [WORD_W-1:0] SQRT2_FIX = WORD_W'(SQRT2_L);

   localparam longint GAIN_P_L = 64'd1 << FRAC_BITS;
   localparam longint PERIOD_L = (64'd655 << FRAC_BITS) >> 16;
   localparam longint RATE_L   = 64'd100 << FRAC_BITS;
   localparam longint LIMIT_L  = (64'd1143821 << FRAC_BITS) >> 16;

   localparam logic [CFG_W-1:0] GAIN_P_RST = CFG_W'(GAIN_P_L);
   localparam logic [CFG_W-1:0] PERIOD_RST = CFG_W'(PERIOD_L);
   localparam logic [CFG_W-1:0] RATE_RST   = CFG_W'(RATE_L);
   localparam logic [CFG_W-1:0] LIMIT_RST  = CFG_W'(LIMIT_L);

   // register indexes
   typedef enum logic [IDX_W-1:0] {
      REG_GAIN_P   = 3'd0,
      REG_GAIN_I   = 3'd1,
      REG_GAIN_D   = 3'd2,
      REG_PERIOD   = 3'd3,
      REG_RATE     = 3'd4,
      REG_CUTOFF   = 3'd5,
      REG_LIMIT    = 3'd6
   } reg_idx_type;

   // microprogram step addresses
   localparam logic [PC_W-1:0] S_ISSUE_RAW = 4'd0;
   localparam logic [PC_W-1:0] S_SAVE_RAW  = 4'd1;
   localparam logic [PC_W-1:0] S_SAVE_WSQ  = 4'd2;
   localparam logic [PC_W-1:0] S_SAVE_K    = 4'd3;
   localparam logic [PC_W-1:0] S_VDOT_0    = 4'd4;
   localparam logic [PC_W-1:0] S_VDOT_1    = 4'd5;
   localparam logic [PC_W-1:0] S_VDOT_2    = 4'd6;
   localparam logic [PC_W-1:0] S_VEL_MUL   = 4'd7;
   localparam logic [PC_W-1:0] S_VEL_ADD   = 4'd8;
   localparam logic [PC_W-1:0] S_POS_ADD   = 4'd9;
   localparam logic [PC_W-1:0] S_RATE      = 4'd10;
   localparam logic [PC_W-1:0] S_INT       = 4'd11;
   localparam logic [PC_W-1:0] S_OUT_0     = 4'd12;
   localparam logic [PC_W-1:0] S_OUT_1     = 4'd13;
   localparam logic [PC_W-1:0] S_OUT_2     = 4'd14;

   // multiplier operand a
   typedef enum logic [3:0] {
      A_DIFF  = 4'd0,
      A_CUT   = 4'd1,
      A_SQRT2 = 4'd2,
      A_WSQ   = 4'd3,
      A_K     = 4'd4,
      A_VDOT  = 4'd5,
      A_VEL   = 4'd6,
      A_GP    = 4'd7,
      A_GI    = 4'd8,
      A_GD    = 4'd9
   } opa_type;

   // multiplier operand b
   typedef enum logic [3:0] {
      B_LRATE = 4'd0,
      B_CUT   = 4'd1,
      B_U     = 4'd2,
      B_VEL   = 4'd3,
      B_POS   = 4'd4,
      B_DT    = 4'd5,
      B_ERR   = 4'd6,
      B_TOTAL = 4'd7,
      B_ERATE = 4'd8
   } opb_type;

   // accumulator operation on the previous product
   typedef enum logic [2:0] {
      ACC_HOLD = 3'd0,
      ACC_LOAD = 3'd1,
      ACC_ADD  = 3'd2,
      ACC_SUB  = 3'd3,
      ACC_VEL  = 3'd4,
      ACC_POS  = 3'd5
   } acc_op_type;

   // write-back destination
   typedef enum logic [3:0] {
      DST_NONE   = 4'd0,
      DST_U      = 4'd1,
      DST_WSQ    = 4'd2,
      DST_K      = 4'd3,
      DST_VDOT   = 4'd4,
      DST_VNEW   = 4'd5,
      DST_COMMIT = 4'd6,
      DST_RATE   = 4'd7,
      DST_INT    = 4'd8,
      DST_OUT    = 4'd9
   } dst_type;

   // jump conditions
   typedef enum logic [1:0] {
      C_NONE      = 2'd0,
      C_DIFF_ZERO = 2'd1,
      C_CUT_ZERO  = 2'd2
   } cond_type;

   typedef struct packed {
      opa_type         a_sel;
      opb_type         b_sel;
      acc_op_type      acc_op;
      dst_type         dst;
      cond_type        cond;
      logic [PC_W-1:0] target;
      logic            last;
   } ucode_type;

   typedef struct packed {
      logic diff_zero;
      logic cut_zero;
   } dp_status_type;

   typedef struct packed {
      logic step_en;
      logic load_err;
   } seq_ctl_type;

   typedef struct packed {
      logic            busy;
      logic [PC_W-1:0] pc;
   } seq_state_type;

   // clamp an accumulator value to the signed word range
   function automatic logic [WORD_W-1:0] sat_word(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = {{(ACC_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
      lo = {{(ACC_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};
      if (x > hi) begin
         return hi[WORD_W-1:0];
      end else if (x < lo) begin
         return lo[WORD_W-1:0];
      end
      return x[WORD_W-1:0];
   endfunction

endpackage
`default_nettype wire

@@ src/pid_with_filtered_derivative.sv @@
// program: an unchanged error jumps to the error-sum step, with the filter off the filter
//    steps are skipped, with it on all steps run; one microprogram step per cycle on one
//    shared multiplier, but the last step waits while the previous result is unclaimed
// input is taken again the cycle after a result is produced, while it sits unclaimed
// reset: synchronous, active high; clears the loop state and the handshake, restores the
//    configuration registers to their defaults
`default_nettype none
module pid_with_filtered_derivative (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // req_tdata: error_sample[31:0]
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [pwfd_pkg::WORD_W-1:0]   req_tdata,
   // rsp_tdata: drive_value[31:0]
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [pwfd_pkg::WORD_W-1:0]        rsp_tdata,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [pwfd_pkg::IDX_W-1:0]    csr_index,
   input  wire logic [pwfd_pkg::CFG_W-1:0]    csr_data
);
   import pwfd_pkg::*;

   ucode_type     uc;
   dp_status_type status;
   seq_ctl_type   ctl;
   seq_state_type state;

   assign csr_ready = 1'b1;

   // sequencer, program table and datapath
   pwfd_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .uc         (uc),
      .status     (status),
      .ctl        (ctl),
      .state      (state)
   );

   pwfd_ucode_rom u_rom (
      .pc (state.pc),
      .uc (uc)
   );

   pwfd_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg_we    (csr_valid && csr_ready),
      .cfg_index (csr_index),
      .cfg_data  (csr_data),
      .err_in    (req_tdata),
      .ctl       (ctl),
      .uc        (uc),
      .status    (status),
      .drive     (rsp_tdata)
   );

`ifndef ASSERT_OFF
   // an accepted word starts the program at its first step
   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state.busy && state.pc == S_ISSUE_RAW))
      else $error("program did not start on accepted word");

   // the step counter stays inside the program
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      state.busy |-> (state.pc <= S_OUT_2))
      else $error("step counter outside program");

   // finishing the last step presents a result and frees the input
   a_finish: assert property (@(posedge clock) disable iff (reset)
      (state.busy && uc.last && ctl.step_en) |=> (rsp_tvalid && !state.busy))
      else $error("finished word not presented");

   // no step advances while idle
   a_idle: assert property (@(posedge clock) disable iff (reset)
      !state.busy |-> !ctl.step_en)
      else $error("step enabled while idle");
`endif

endmodule
`default_nettype wire

@@ src/pwfd_ucode_rom.sv @@
`default_nettype none
module pwfd_ucode_rom (
   input  wire logic [pwfd_pkg::PC_W-1:0] pc,
   output pwfd_pkg::ucode_type            uc
);
   import pwfd_pkg::*;

   // one control word per step; issue field starts a product, acc field uses the last one
   always_comb begin
      uc = '{a_sel: A_DIFF, b_sel: B_LRATE, acc_op: ACC_HOLD, dst: DST_NONE,
             cond: C_NONE, target: S_ISSUE_RAW, last: 1'b0};
      unique case (pc)
         S_ISSUE_RAW: begin
            uc.a_sel  = A_DIFF;
            uc.b_sel  = B_LRATE;
            uc.cond   = C_DIFF_ZERO;
            uc.target = S_INT;
         end
         S_SAVE_RAW: begin
            uc.a_sel  = A_CUT;
            uc.b_sel  = B_CUT;
            uc.acc_op = ACC_LOAD;
            uc.dst    = DST_U;
            uc.cond   = C_CUT_ZERO;
            uc.target = S_RATE;
         end
         S_SAVE_WSQ: begin
            uc.a_sel  = A_SQRT2;
            uc.b_sel  = B_CUT;
            uc.acc_op = ACC_LOAD;
            uc.dst    = DST_WSQ;
         end
         S_SAVE_K: begin
            uc.a_sel  = A_WSQ;
            uc.b_sel  = B_U;
            uc.acc_op = ACC_LOAD;
            uc.dst    = DST_K;
         end
         S_VDOT_0: begin
            uc.a_sel  = A_K;
            uc.b_sel  = B_VEL;
            uc.acc_op = ACC_LOAD;
         end
         S_VDOT_1: begin
            uc.a_sel  = A_WSQ;
            uc.b_sel  = B_POS;
            uc.acc_op = ACC_SUB;
         end
         S_VDOT_2: begin
            uc.acc_op = ACC_SUB;
            uc.dst    = DST_VDOT;
         end
         S_VEL_MUL: begin
            uc.a_sel  = A_VDOT;
            uc.b_sel  = B_DT;
         end
         S_VEL_ADD: begin
            uc.a_sel  = A_VEL;
            uc.b_sel  = B_DT;
            uc.acc_op = ACC_VEL;
            uc.dst    = DST_VNEW;
         end
         S_POS_ADD: begin
            uc.acc_op = ACC_POS;
            uc.dst    = DST_COMMIT;
         end
         S_RATE: begin
            uc.dst    = DST_RATE;
         end
         S_INT: begin
            uc.a_sel  = A_GP;
            uc.b_sel  = B_ERR;
            uc.dst    = DST_INT;
         end
         S_OUT_0: begin
            uc.a_sel  = A_GI;
            uc.b_sel  = B_TOTAL;
            uc.acc_op = ACC_LOAD;
         end
         S_OUT_1: begin
            uc.a_sel  = A_GD;
            uc.b_sel  = B_ERATE;
            uc.acc_op = ACC_ADD;
         end
         S_OUT_2: begin
            uc.acc_op = ACC_ADD;
            uc.dst    = DST_OUT;
            uc.last   = 1'b1;
         end
         default: begin
            uc.last   = 1'b1;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ src/pwfd_sequencer.sv @@
`default_nettype none
module pwfd_sequencer (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   input  pwfd_pkg::ucode_type          uc,
   input  pwfd_pkg::dp_status_type      status,
   output pwfd_pkg::seq_ctl_type        ctl,
   output pwfd_pkg::seq_state_type      state
);
   import pwfd_pkg::*;

   logic            busy_ff, busy_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            accept;
   logic            jump;

   // last step waits while the output word is still unclaimed
   assign accept       = req_tvalid && !busy_ff;
   assign ctl.load_err = accept;
   assign ctl.step_en  = busy_ff && !(uc.last && rsp_valid_ff && !rsp_tready);

   // jump condition select
   always_comb begin
      unique case (uc.cond)
         C_NONE:      jump = 1'b0;
         C_DIFF_ZERO: jump = status.diff_zero;
         C_CUT_ZERO:  jump = status.cut_zero;
         default:     jump = 1'b0;
      endcase
   end

   // step counter and handshake state
   always_comb begin
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (accept) begin
         busy_in = 1'b1;
         pc_in   = S_ISSUE_RAW;
      end else if (ctl.step_en) begin
         if (uc.last) begin
            busy_in      = 1'b0;
            rsp_valid_in = 1'b1;
         end else if (jump) begin
            pc_in = uc.target;
         end else begin
            pc_in = pc_ff + PC_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= S_ISSUE_RAW;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = !busy_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign state.busy = busy_ff;
   assign state.pc   = pc_ff;

endmodule
`default_nettype wire

@@ src/pwfd_datapath.sv @@
`default_nettype none
module pwfd_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            cfg_we,
   input  wire logic [pwfd_pkg::IDX_W-1:0]      cfg_index,
   input  wire logic [pwfd_pkg::CFG_W-1:0]      cfg_data,
   input  wire logic [pwfd_pkg::WORD_W-1:0]     err_in,
   input  pwfd_pkg::seq_ctl_type                ctl,
   input  pwfd_pkg::ucode_type                  uc,
   output pwfd_pkg::dp_status_type              status,
   output logic [pwfd_pkg::WORD_W-1:0]          drive
);
   import pwfd_pkg::*;

   // configuration
   logic [CFG_W-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [CFG_W-1:0] period_ff, lrate_ff, cutoff_ff, limit_ff;

   // loop state
   logic signed [WORD_W-1:0] prev_ff, total_ff, erate_ff, vel_ff, pos_ff;
   logic signed [WORD_W-1:0] total_in;

   // scratch and working registers
   logic signed [WORD_W-1:0] err_ff;
   logic signed [WORD_W-1:0] u_ff, wsq_ff, k_ff, vdot_ff, vnew_ff, drive_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   logic signed [OPA_W-1:0]  opa;
   logic signed [OPB_W-1:0]  opb;
   logic signed [OPA_W-1:0]  diff;
   logic signed [PROD_W-1:0] prod_shift;
   logic signed [SH_W-1:0]   prod_sh;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [ACC_W-1:0]  vel_ext, pos_ext;
   logic [WORD_W-1:0]        acc_sat;
   logic signed [OPA_W-1:0]  sum33, lim_pos, lim_neg;

   assign diff             = {err_ff[WORD_W-1], err_ff} - {prev_ff[WORD_W-1], prev_ff};
   assign status.diff_zero = (err_ff == prev_ff);
   assign status.cut_zero  = (cutoff_ff == '0);

   // operand a select
   always_comb begin
      unique case (uc.a_sel)
         A_DIFF:  opa = diff;
         A_CUT:   opa = {2'b00, cutoff_ff};
         A_SQRT2: opa = {1'b0, SQRT2_FIX};
         A_WSQ:   opa = {wsq_ff[WORD_W-1], wsq_ff};
         A_K:     opa = {k_ff[WORD_W-1], k_ff};
         A_VDOT:  opa = {vdot_ff[WORD_W-1], vdot_ff};
         A_VEL:   opa = {vel_ff[WORD_W-1], vel_ff};
         A_GP:    opa = {2'b00, gain_p_ff};
         A_GI:    opa = {2'b00, gain_i_ff};
         A_GD:    opa = {2'b00, gain_d_ff};
         default: opa = diff;
      endcase
   end

   // operand b select
   always_comb begin
      unique case (uc.b_sel)
         B_LRATE: opb = {1'b0, lrate_ff};
         B_CUT:   opb = {1'b0, cutoff_ff};
         B_U:     opb = u_ff;
         B_VEL:   opb = vel_ff;
         B_POS:   opb = pos_ff;
         B_DT:    opb = {1'b0, period_ff};
         B_ERR:   opb = err_ff;
         B_TOTAL: opb = total_ff;
         B_ERATE: opb = erate_ff;
         default: opb = u_ff;
      endcase
   end

   // shared multiplier, product registered
   assign prod_in = PROD_W'(opa) * PROD_W'(opb);

   // floor shift of the previous product
   assign prod_shift = prod_ff >>> FRAC_BITS;
   assign prod_sh    = prod_shift[SH_W-1:0];
   assign prod_ext   = {{(ACC_W-SH_W){prod_sh[SH_W-1]}}, prod_sh};
   assign vel_ext    = {{(ACC_W-WORD_W){vel_ff[WORD_W-1]}}, vel_ff};
   assign pos_ext    = {{(ACC_W-WORD_W){pos_ff[WORD_W-1]}}, pos_ff};

   // accumulator
   always_comb begin
      unique case (uc.acc_op)
         ACC_HOLD: acc_in = acc_ff;
         ACC_LOAD: acc_in = prod_ext;
         ACC_ADD:  acc_in = acc_ff + prod_ext;
         ACC_SUB:  acc_in = acc_ff - prod_ext;
         ACC_VEL:  acc_in = vel_ext + prod_ext;
         ACC_POS:  acc_in = pos_ext + prod_ext;
         default:  acc_in = acc_ff;
      endcase
   end

   assign acc_sat = sat_word(acc_in);

   // clamped error sum
   assign sum33   = {total_ff[WORD_W-1], total_ff} + {err_ff[WORD_W-1], err_ff};
   assign lim_pos = {2'b00, limit_ff};
   assign lim_neg = -lim_pos;
   always_comb begin
      priority if (sum33 > lim_pos) begin
         total_in = lim_pos[WORD_W-1:0];
      end else if (sum33 < lim_neg) begin
         total_in = lim_neg[WORD_W-1:0];
      end else begin
         total_in = sum33[WORD_W-1:0];
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff <= GAIN_P_RST;
         gain_i_ff <= '0;
         gain_d_ff <= '0;
         period_ff <= PERIOD_RST;
         lrate_ff  <= RATE_RST;
         cutoff_ff <= '0;
         limit_ff  <= LIMIT_RST;
      end else if (cfg_we) begin
         unique case (cfg_index)
            REG_GAIN_P: gain_p_ff <= cfg_data;
            REG_GAIN_I: gain_i_ff <= cfg_data;
            REG_GAIN_D: gain_d_ff <= cfg_data;
            REG_PERIOD: period_ff <= cfg_data;
            REG_RATE:   lrate_ff  <= cfg_data;
            REG_CUTOFF: cutoff_ff <= cfg_data;
            REG_LIMIT:  limit_ff  <= cfg_data;
            default: begin
            end
         endcase
      end
   end

   // loop state write-back
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         total_ff <= '0;
         erate_ff <= '0;
         vel_ff   <= '0;
         pos_ff   <= '0;
      end else if (ctl.step_en) begin
         unique case (uc.dst)
            DST_COMMIT: begin
               vel_ff <= vnew_ff;
               pos_ff <= acc_sat;
            end
            DST_RATE: erate_ff <= u_ff;
            DST_INT: begin
               prev_ff  <= err_ff;
               total_ff <= total_in;
            end
            default: begin
            end
         endcase
      end
   end

   // scratch write-back
   always_ff @(posedge clock) begin
      if (ctl.step_en) begin
         unique case (uc.dst)
            DST_U:      u_ff     <= acc_sat;
            DST_WSQ:    wsq_ff   <= acc_sat;
            DST_K:      k_ff     <= acc_sat;
            DST_VDOT:   vdot_ff  <= acc_sat;
            DST_VNEW:   vnew_ff  <= acc_sat;
            DST_COMMIT: u_ff     <= acc_sat;
            DST_OUT:    drive_ff <= acc_sat;
            default: begin
            end
         endcase
         prod_ff <= prod_in;
         acc_ff  <= acc_in;
      end
   end

   // input word
   always_ff @(posedge clock) begin
      if (ctl.load_err) begin
         err_ff <= err_in;
      end
   end

   assign drive = drive_ff;

endmodule
`default_nettype wire

@@ verif/pid_with_filtered_derivative_tb.sv @@
module pid_with_filtered_derivative_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pwfd_pkg::*;

   localparam longint WORD_HI       = 64'sd2147483647;
   localparam longint WORD_LO       = -64'sd2147483648;
   localparam int     PHASES        = 10;
   localparam int     PHASE_ITEMS   = 73;
   localparam int     SETTLE_CYCLES = 20;
   localparam int     LONG_HOLD     = 300;
   localparam int     TIMEOUT_NS    = 5_000_000;

   // register index that decodes to nothing
   localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

   // kinds of register setting per phase
   localparam int PH_CALM   = 0;
   localparam int PH_FILTER = 1;
   localparam int PH_MAX    = 2;
   localparam int PH_MIN    = 3;
   localparam int PH_MIXED  = 4;

   // tracks the controller state and the drive words it owes
   class drive_scoreboard;
      logic [CFG_W-1:0]        cfg [7];
      logic signed [WORD_W-1:0] prev_err, err_total, err_rate, flt_vel, flt_pos;
      logic [WORD_W-1:0]       drive_expected [$];
      int unsigned             n_taken, n_checked, n_bad, n_writes;

      function new();
         cfg[REG_GAIN_P] = GAIN_P_RST;
         cfg[REG_GAIN_I] = '0;
         cfg[REG_GAIN_D] = '0;
         cfg[REG_PERIOD] = PERIOD_RST;
         cfg[REG_RATE]   = RATE_RST;
         cfg[REG_CUTOFF] = '0;
         cfg[REG_LIMIT]  = LIMIT_RST;
         prev_err  = '0;
         err_total = '0;
         err_rate  = '0;
         flt_vel   = '0;
         flt_pos   = '0;
      endfunction

      static function longint sat32(longint x);
         if (x > WORD_HI) begin
            return WORD_HI;
         end else if (x < WORD_LO) begin
            return WORD_LO;
         end
         return x;
      endfunction

      // product scaled back to the fraction width, floor rounding
      static function longint mulsh(longint a, longint b);
         return (a * b) >>> FRAC_BITS;
      endfunction

      function longint cv(reg_idx_type r);
         return longint'({1'b0, cfg[r]});
      endfunction

      function int unsigned pending();
         return drive_expected.size();
      endfunction

      function void note_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
         n_writes++;
         if (idx <= REG_LIMIT) begin
            cfg[idx] = data;
         end
      endfunction

      // one loop step: update state, queue the drive word
      function void note_error(logic [WORD_W-1:0] word);
         longint e, diff, u, w, wsq, k, vel, pos, vdot, vnew, pnew, sum, lim, drive;
         e    = longint'($signed(word));
         diff = e - longint'(prev_err);
         if (diff != 0) begin
            u = sat32(mulsh(diff, cv(REG_RATE)));
            w = cv(REG_CUTOFF);
            if (w != 0) begin
               vel  = longint'(flt_vel);
               pos  = longint'(flt_pos);
               wsq  = sat32(mulsh(w, w));
               k    = sat32(mulsh(longint'({1'b0, SQRT2_FIX}), w));
               vdot = sat32(mulsh(wsq, u) - mulsh(k, vel) - mulsh(wsq, pos));
               vnew = sat32(vel + mulsh(vdot, cv(REG_PERIOD)));
               pnew = sat32(pos + mulsh(vel, cv(REG_PERIOD)));
               flt_vel = WORD_W'(vnew);
               flt_pos = WORD_W'(pnew);
               u = pnew;
            end
            err_rate = WORD_W'(u);
         end
         prev_err = WORD_W'(e);

         // clamped error sum
         lim = cv(REG_LIMIT);
         sum = longint'(err_total) + e;
         if (sum > lim) begin
            sum = lim;
         end else if (sum < -lim) begin
            sum = -lim;
         end
         err_total = WORD_W'(sum);

         drive = sat32(mulsh(cv(REG_GAIN_P), e) + mulsh(cv(REG_GAIN_I), sum)
                       + mulsh(cv(REG_GAIN_D), longint'(err_rate)));
         drive_expected.push_back(WORD_W'(drive));
         n_taken++;
      endfunction

      function void check_drive(logic [WORD_W-1:0] got);
         logic [WORD_W-1:0] want;
         if (drive_expected.size() == 0) begin
            n_bad++;
            if (n_bad <= 10) begin
               $display("drive word %h arrived with nothing outstanding", got);
            end
         end else begin
            want = drive_expected.pop_front();
            if (got !== want) begin
               n_bad++;
               if (n_bad <= 10) begin
                  $display("drive word %0d: expected %h, got %h", n_checked, want, got);
               end
            end
            n_checked++;
         end
      endfunction
   endclass

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic [WORD_W-1:0]   req_tdata  = '0;
   logic                rsp_tready = 1'b0;
   logic                csr_valid  = 1'b0;
   logic [IDX_W-1:0]    csr_index  = '0;
   logic [CFG_W-1:0]    csr_data   = '0;
   wire                 req_tready;
   wire                 rsp_tvalid;
   wire  [WORD_W-1:0]   rsp_tdata;
   wire                 csr_ready;

   logic                tx_idle_on    = 1'b1;
   logic                rx_idle_on    = 1'b1;
   logic                backlog_req   = 1'b0;
   logic                backlog_taken = 1'b0;
   int unsigned         rx_hold       = 0;
   int unsigned         n_settings    = 0;

   drive_scoreboard sb = new();

   logic [WORD_W-1:0] directed_a [0:9] = '{
      32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001,
      32'hFFFF_FFFF, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000};
   logic [WORD_W-1:0] directed_b [0:7] = '{
      32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0000_0000,
      32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF};

   pid_with_filtered_derivative u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // observe every handshake at the edge it completes
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            sb.note_reg(csr_index, csr_data);
         end
         if (req_tvalid && req_tready) begin
            sb.note_error(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_drive(rsp_tdata);
         end
      end
   end

   // result side: random stall bursts and one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready    <= 1'b0;
         rx_hold       <= 0;
         backlog_taken <= 1'b0;
      end else if (rx_hold != 0) begin
         rsp_tready <= 1'b0;
         rx_hold    <= rx_hold - 1;
      end else if (backlog_req && !backlog_taken) begin
         rsp_tready    <= 1'b0;
         rx_hold       <= LONG_HOLD - 1;
         backlog_taken <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         rx_hold    <= $urandom_range(0, 17);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // offer one error word, with an optional gap in front
   task automatic send_error(input logic [WORD_W-1:0] w);
      if (tx_idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // valid stays high so back-to-back writes need no extra step
   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // wait for every drive word, then let the datapath go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // program all registers for one phase
   task automatic set_phase(input int kind);
      logic [CFG_W-1:0] val [7];
      logic [CFG_W-1:0] dt;
      int unsigned      pick;
      dt = CFG_W'($urandom_range(65, 6554));
      val[REG_GAIN_P] = CFG_W'($urandom_range(0, 4 << FRAC_BITS));
      val[REG_GAIN_I] = CFG_W'($urandom_range(0, 1 << FRAC_BITS));
      val[REG_GAIN_D] = CFG_W'($urandom_range(0, 1 << (FRAC_BITS - 2)));
      val[REG_PERIOD] = dt;
      val[REG_RATE]   = CFG_W'((64'd1 << (2 * FRAC_BITS)) / dt);
      val[REG_CUTOFF] = (kind == PH_CALM) ? '0
                        : CFG_W'($urandom_range(1 << FRAC_BITS, 150 << FRAC_BITS));
      val[REG_LIMIT]  = CFG_W'($urandom_range(0, 1 << 24));
      for (int r = 0; r < 7; r++) begin
         pick = (kind == PH_MIXED) ? $urandom_range(0, 3) : 2;
         if (kind == PH_MAX || pick == 1) begin
            val[r] = '1;
         end else if (kind == PH_MIN || pick == 0) begin
            val[r] = (r == REG_PERIOD || r == REG_RATE) ? CFG_W'(1) : '0;
         end else if (pick == 3) begin
            val[r] = CFG_W'($urandom());
         end
      end
      for (int r = 0; r < 7; r++) begin
         write_reg(IDX_W'(r), val[r]);
      end
      if (kind == PH_MIXED) begin
         write_reg(REG_SPARE, CFG_W'($urandom()));
      end
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   // control-loop-like error stream with repeats, jumps and extremes
   function automatic logic [WORD_W-1:0] next_error(input logic [WORD_W-1:0] last);
      int step;
      step = int'($urandom_range(0, 1 << 17)) - (1 << 16);
      case ($urandom_range(0, 9))
         0, 1: return last;
         2: return $urandom();
         3: begin
            case ($urandom_range(0, 4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               3: return 32'h0000_0001;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         4: return WORD_W'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
         default: return last + WORD_W'(step);
      endcase
   endfunction

   initial begin : stimulus
      logic [WORD_W-1:0] err_word;
      int                kind;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: extremes, sign flips, unchanged errors
      foreach (directed_a[i]) begin
         send_error(directed_a[i]);
      end
      settle();

      // filter switched on with small gains
      write_reg(REG_GAIN_I, CFG_W'(1 << (FRAC_BITS - 1)));
      write_reg(REG_GAIN_D, CFG_W'(1 << (FRAC_BITS - 4)));
      write_reg(REG_CUTOFF, CFG_W'(40 << FRAC_BITS));
      csr_valid <= 1'b0;
      n_settings++;
      foreach (directed_b[i]) begin
         send_error(directed_b[i]);
      end
      err_word = directed_b[7];

      // random phases, last one without idling
      for (int p = 1; p <= PHASES; p++) begin
         settle();
         if (p == PHASES) begin
            tx_idle_on  = 1'b0;
            rx_idle_on <= 1'b0;
         end else begin
            tx_idle_on  = ($urandom_range(0, 3) != 0);
            rx_idle_on <= ($urandom_range(0, 3) != 0);
         end
         if (p <= 4) begin
            kind = p - 1;
         end else if (p == PHASES) begin
            kind = PH_FILTER;
         end else begin
            kind = PH_MIXED;
         end
         set_phase(kind);
         if (p == 2) begin
            backlog_req <= 1'b1;
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            err_word = next_error(err_word);
            send_error(err_word);
         end
      end
      settle();

      $display("%0d error samples sent, %0d drive words checked, %0d register writes",
               sb.n_taken, sb.n_checked, sb.n_writes);
      $display("%0d register settings incl. zero and full-scale, filter on and off, %0d-cycle backlog",
               n_settings, LONG_HOLD);
      if (sb.n_bad == 0 && sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #TIMEOUT_NS;
      $display("timed out with %0d drive words outstanding", sb.pending());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
